// ===== rtl/desa_pkg.sv =====
// desa_pkg: shared constants, codes and types for the double-ended stack allocator.
// Depends on nothing; imported by the allocator top level.
`timescale 1ns / 1ps
package desa_pkg;

   // parameter defaults
   localparam int MARKS_PER_SIDE_DEF = 32;
   localparam int POS_WIDTH_DEF      = 32;
   localparam int TAG_BITS_DEF       = 16;

   localparam int SIDES = 2;

   // port field widths
   localparam int MODE_W   = 2;
   localparam int TAG_W    = 16;
   localparam int SIZE_W   = 32;
   localparam int ALIGN_W  = 5;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 3;
   localparam int CSR_W    = 32;

   localparam logic [CSR_W-1:0] TOTAL_SIZE_RESET = 32'h2000_0000;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam mode_type MODE_BEGIN = 2'd0;
   localparam mode_type MODE_END   = 2'd1;
   localparam mode_type MODE_ALLOC = 2'd2;
   localparam mode_type MODE_FREE  = 2'd3;

   localparam status_type STAT_OK           = 3'd0;
   localparam status_type STAT_OOM          = 3'd1;
   localparam status_type STAT_LIST_FULL    = 3'd2;
   localparam status_type STAT_MARK_OPEN    = 3'd3;
   localparam status_type STAT_TAG_MISMATCH = 3'd4;
   localparam status_type STAT_NOT_NEWEST   = 3'd5;
   localparam status_type STAT_NOT_FOUND    = 3'd6;
   localparam status_type STAT_NO_OPEN      = 3'd7;

endpackage

// ===== rtl/desa_ram.sv =====
// desa_ram: generic single-write, single-read RAM with registered read data.
// Self-contained; instanced once per side for the mark list.
`timescale 1ns / 1ps
module desa_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/double_ended_stack_allocator_unit.sv =====
// double_ended_stack_allocator_unit: two-ended arena allocator with tagged marks.
// Depends on desa_pkg and desa_ram (one mark-list RAM per side).
`timescale 1ns / 1ps
//
// Usage
//  - Request channel (req_*): mode, side, tag, alloc_size, align_log2 under
//    valid/ready. One request is worked on at a time; req_ready is low while
//    the sequencer is busy with it.
//  - Response channel (rsp_*): one response per request, address and status,
//    held in an output register until rsp_ready. A new request may be taken
//    while the previous response still waits; the next one parks in the
//    output step until the register frees up.
//  - csr_wr_en/csr_wr_data write total_size and reinitialise the arena: the
//    low side goes to zero, the high side to total_size, all marks drop.
//  - Steps per request: begin and end mark go from accept straight to the
//    output step, allocate passes the allocate step first, free by tag
//    scans the mark RAMs up to the larger mark count of the two sides, one
//    entry per cycle on both sides at once, then checks and runs the pop
//    walk over the live bits, one mark per cycle, past already freed marks.
//  - Reset (synchronous) restores total_size to its default, empties both
//    mark lists and drops any pending response. The mark RAM contents are
//    never cleared: an entry is only used after it has been written.
//
module double_ended_stack_allocator_unit #(
   parameter int MARKS_PER_SIDE = desa_pkg::MARKS_PER_SIDE_DEF,
   parameter int POS_WIDTH      = desa_pkg::POS_WIDTH_DEF,
   parameter int TAG_BITS       = desa_pkg::TAG_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [desa_pkg::MODE_W-1:0]    req_mode,
   input  logic                           req_side,
   input  logic [desa_pkg::TAG_W-1:0]     req_tag,
   input  logic [desa_pkg::SIZE_W-1:0]    req_alloc_size,
   input  logic [desa_pkg::ALIGN_W-1:0]   req_align_log2,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [desa_pkg::ADDR_W-1:0]    rsp_address,
   output logic [desa_pkg::STATUS_W-1:0]  rsp_status,
   // configuration
   input  logic                           csr_wr_en,
   input  logic [desa_pkg::CSR_W-1:0]     csr_wr_data
);

   import desa_pkg::*;

   localparam int PW = POS_WIDTH;
   localparam int TW = TAG_BITS;
   localparam int IW = $clog2(MARKS_PER_SIDE);
   localparam int CW = $clog2(MARKS_PER_SIDE + 1);
   localparam int EW = ((PW > ADDR_W) ? PW : ADDR_W) + 2;   // exact sum width
   localparam int RW = TW + PW;                              // {tag, position}

   localparam logic [CW-1:0] MarksCnt = CW'(MARKS_PER_SIDE);
   localparam logic [EW-1:0] OneE     = EW'(1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ALLOC = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_POP   = 3'd4;
   localparam logic [2:0] ST_POPRD = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   // ---------------------------------------------------------------- state
   logic [2:0]          state_ff, state_in;
   logic [PW-1:0]       low_pos_ff, low_pos_in;
   logic [PW-1:0]       high_pos_ff, high_pos_in;
   logic [MARKS_PER_SIDE-1:0] live_ff [SIDES];
   logic [MARKS_PER_SIDE-1:0] live_in [SIDES];
   logic [CW-1:0]       cnt_ff [SIDES];
   logic [CW-1:0]       cnt_in [SIDES];
   logic [SIDES-1:0]    open_ff, open_in;
   logic [TW-1:0]       open_tag_ff [SIDES];
   logic [TW-1:0]       open_tag_in [SIDES];

   // request being worked on
   logic                op_side_ff, op_side_in;
   logic [TW-1:0]       op_tag_ff, op_tag_in;
   logic [SIZE_W-1:0]   op_size_ff, op_size_in;
   logic [EW-1:0]       op_amask_ff, op_amask_in;
   logic [EW-1:0]       acc_ff, acc_in;

   // pending result
   status_type          res_status_ff, res_status_in;
   logic                res_have_ff, res_have_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;

   // free-by-tag scan and pop walk
   logic [CW-1:0]       scan_idx_ff, scan_idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [SIDES-1:0]    found_ff, found_in;
   logic [IW-1:0]       fidx_ff [SIDES];
   logic [IW-1:0]       fidx_in [SIDES];
   logic [SIDES-1:0]    pop_act_ff, pop_act_in;
   logic [IW-1:0]       pop_cnt_ff [SIDES];
   logic [IW-1:0]       pop_cnt_in [SIDES];

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_address_ff, rsp_address_in;
   status_type          rsp_status_ff, rsp_status_in;

   // mark RAM ports
   logic [SIDES-1:0]    ram_we;
   logic [IW-1:0]       ram_waddr;
   logic [RW-1:0]       ram_wdata;
   logic [IW-1:0]       ram_raddr [SIDES];
   logic [RW-1:0]       ram_rdata [SIDES];

   // ---------------------------------------------------------------- helpers
   logic                req_acc;
   logic [TW+TAG_W-1:0] tag_ext;
   logic [TW-1:0]       tag_eff;
   logic [PW+CSR_W-1:0] csr_ext, rst_ext;
   logic [PW-1:0]       csr_size, rst_size;
   logic [PW-1:0]       req_pos;
   logic [EW-1:0]       low_e, high_e, req_size_e, op_size_e, amask_req;
   logic [EW-1:0]       alc_start, alc_end;
   logic [PW+ADDR_W-1:0] side_pos_ext;
   logic [CW-1:0]       max_cnt;
   logic [CW+IW-1:0]    cmp_ext;
   logic [SIDES-1:0]    hit;
   logic [SIDES-1:0]    pop_step;
   logic [CW+IW-1:0]    fidx_ext [SIDES];
   logic [CW+IW-1:0]    pop_ext [SIDES];
   status_type          chk_status;
   logic [SIDES-1:0]    top_live_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;

   // tag masked to TAG_BITS, total size masked or widened to POS_WIDTH
   assign tag_ext  = {{TW{1'b0}}, req_tag};
   assign tag_eff  = tag_ext[TW-1:0];
   assign csr_ext  = {{PW{1'b0}}, csr_wr_data};
   assign csr_size = csr_ext[PW-1:0];
   assign rst_ext  = {{PW{1'b0}}, TOTAL_SIZE_RESET};
   assign rst_size = rst_ext[PW-1:0];

   assign req_pos    = req_side ? high_pos_ff : low_pos_ff;
   assign low_e      = {{(EW-PW){1'b0}}, low_pos_ff};
   assign high_e     = {{(EW-PW){1'b0}}, high_pos_ff};
   assign req_size_e = {{(EW-SIZE_W){1'b0}}, req_alloc_size};
   assign op_size_e  = {{(EW-SIZE_W){1'b0}}, op_size_ff};
   assign amask_req  = (OneE << req_align_log2) - OneE;

   // second allocate step: align the first-step sum, then extend by the size
   assign alc_start = acc_ff & ~op_amask_ff;
   assign alc_end   = alc_start + op_size_e;

   assign side_pos_ext = {{ADDR_W{1'b0}}, (op_side_ff ? high_pos_ff : low_pos_ff)};

   assign max_cnt = (cnt_ff[0] > cnt_ff[1]) ? cnt_ff[0] : cnt_ff[1];
   assign cmp_ext = {{CW{1'b0}}, cmp_idx_ff};

   always_comb begin
      for (int s = 0; s < SIDES; s++) begin
         hit[s] = (cmp_ext[CW-1:0] < cnt_ff[s]) && live_ff[s][cmp_idx_ff]
                  && (ram_rdata[s][RW-1:PW] == op_tag_ff);
         fidx_ext[s] = {{CW{1'b0}}, fidx_ff[s]};
         pop_ext[s]  = {{CW{1'b0}}, pop_cnt_ff[s]};
         // step down past marks that were freed out of order earlier
         pop_step[s] = pop_act_ff[s] && (pop_cnt_ff[s] != '0)
                       && !live_ff[s][pop_cnt_ff[s] - IW'(1)];
         ram_raddr[s] = (state_ff == ST_SCAN) ? scan_idx_ff[IW-1:0] : pop_cnt_ff[s];
      end
   end

   // free check: low side first, first error wins
   always_comb begin
      chk_status = STAT_OK;
      for (int s = 0; s < SIDES; s++) begin
         if (found_ff[s] && (chk_status == STAT_OK)) begin
            if (open_ff[s]) begin
               chk_status = STAT_MARK_OPEN;
            end else if (fidx_ext[s][CW-1:0] + CW'(1) != cnt_ff[s]) begin
               chk_status = STAT_NOT_NEWEST;
            end
         end
      end
      if (found_ff == '0) begin
         chk_status = STAT_NOT_FOUND;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      low_pos_in     = low_pos_ff;
      high_pos_in    = high_pos_ff;
      live_in        = live_ff;
      cnt_in         = cnt_ff;
      open_in        = open_ff;
      open_tag_in    = open_tag_ff;
      op_side_in     = op_side_ff;
      op_tag_in      = op_tag_ff;
      op_size_in     = op_size_ff;
      op_amask_in    = op_amask_ff;
      acc_in         = acc_ff;
      res_status_in  = res_status_ff;
      res_have_in    = res_have_ff;
      res_addr_in    = res_addr_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_vld_in     = cmp_vld_ff;
      cmp_idx_in     = cmp_idx_ff;
      found_in       = found_ff;
      fidx_in        = fidx_ff;
      pop_act_in     = pop_act_ff;
      pop_cnt_in     = pop_cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;
      ram_we         = '0;
      ram_waddr      = cnt_ff[req_side][IW-1:0];
      ram_wdata      = {tag_eff, req_pos};

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_side_in    = req_side;
               op_tag_in     = tag_eff;
               op_size_in    = req_alloc_size;
               op_amask_in   = amask_req;
               res_status_in = STAT_OK;
               res_have_in   = 1'b0;
               state_in      = ST_OUT;
               unique case (req_mode)
                  MODE_BEGIN: begin
                     if (open_ff[req_side]) begin
                        res_status_in = STAT_MARK_OPEN;
                     end else if (cnt_ff[req_side] >= MarksCnt) begin
                        res_status_in = STAT_LIST_FULL;
                     end else begin
                        // push tag and position, open the mark
                        ram_we[req_side]                         = 1'b1;
                        live_in[req_side][cnt_ff[req_side][IW-1:0]] = 1'b1;
                        cnt_in[req_side]      = cnt_ff[req_side] + CW'(1);
                        open_in[req_side]     = 1'b1;
                        open_tag_in[req_side] = tag_eff;
                     end
                  end
                  MODE_END: begin
                     if (!open_ff[req_side]) begin
                        res_status_in = STAT_NO_OPEN;
                     end else if (open_tag_ff[req_side] != tag_eff) begin
                        res_status_in = STAT_TAG_MISMATCH;
                     end else begin
                        open_in[req_side] = 1'b0;
                     end
                  end
                  MODE_ALLOC: begin
                     // low side: position plus alignment slack; high side:
                     // position minus size, borrow in the top bit
                     acc_in   = req_side ? (high_e - req_size_e) : (low_e + amask_req);
                     state_in = ST_ALLOC;
                  end
                  MODE_FREE: begin
                     scan_idx_in = '0;
                     cmp_vld_in  = 1'b0;
                     found_in    = '0;
                     state_in    = ST_SCAN;
                  end
               endcase
            end
         end

         ST_ALLOC: begin
            state_in = ST_OUT;
            if (!op_side_ff) begin
               if (alc_end > high_e) begin
                  res_status_in = STAT_OOM;
               end else begin
                  low_pos_in  = alc_end[PW-1:0];
                  res_have_in = 1'b1;
                  res_addr_in = alc_start[ADDR_W-1:0];
               end
            end else begin
               if (acc_ff[EW-1] || (alc_start < low_e)) begin
                  res_status_in = STAT_OOM;
               end else begin
                  high_pos_in = alc_start[PW-1:0];
                  res_have_in = 1'b1;
                  res_addr_in = alc_start[ADDR_W-1:0];
               end
            end
         end

         ST_SCAN: begin
            // issue one read per cycle on both sides, compare in the next cycle
            if (scan_idx_ff < max_cnt) begin
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[IW-1:0];
               scan_idx_in = scan_idx_ff + CW'(1);
            end else begin
               cmp_vld_in = 1'b0;
               if (!cmp_vld_ff) begin
                  state_in = ST_CHECK;
               end
            end
            if (cmp_vld_ff) begin
               for (int s = 0; s < SIDES; s++) begin
                  if (!found_ff[s] && hit[s]) begin
                     found_in[s] = 1'b1;
                     fidx_in[s]  = cmp_idx_ff;
                  end
               end
            end
         end

         ST_CHECK: begin
            if (chk_status != STAT_OK) begin
               res_status_in = chk_status;
               state_in      = ST_OUT;
            end else begin
               for (int s = 0; s < SIDES; s++) begin
                  if (found_ff[s]) begin
                     live_in[s][fidx_ff[s]] = 1'b0;
                  end
                  pop_cnt_in[s] = fidx_ff[s];
               end
               pop_act_in = found_ff;
               state_in   = ST_POP;
            end
         end

         ST_POP: begin
            for (int s = 0; s < SIDES; s++) begin
               if (pop_step[s]) begin
                  pop_cnt_in[s] = pop_cnt_ff[s] - IW'(1);
               end
            end
            // read address already points at the final entry when no side steps
            if (pop_step == '0) begin
               state_in = ST_POPRD;
            end
         end

         ST_POPRD: begin
            for (int s = 0; s < SIDES; s++) begin
               if (pop_act_ff[s]) begin
                  cnt_in[s] = pop_ext[s][CW-1:0];
               end
            end
            if (pop_act_ff[0]) begin
               low_pos_in = ram_rdata[0][PW-1:0];
            end
            if (pop_act_ff[1]) begin
               high_pos_in = ram_rdata[1][PW-1:0];
            end
            pop_act_in    = '0;
            res_status_in = STAT_OK;
            state_in      = ST_OUT;
         end

         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_address_in = res_have_ff ? res_addr_ff : side_pos_ext[ADDR_W-1:0];
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // total_size write reinitialises the arena (user issues it only while idle; not enforced here)
      if (csr_wr_en) begin
         low_pos_in  = '0;
         high_pos_in = csr_size;
         open_in     = '0;
         for (int s = 0; s < SIDES; s++) begin
            live_in[s]     = '0;
            cnt_in[s]      = '0;
            open_tag_in[s] = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_pos_ff   <= '0;
         high_pos_ff  <= rst_size;
         open_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= '0;
         pop_act_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SIDES; s++) begin
            live_ff[s]     <= '0;
            cnt_ff[s]      <= '0;
            open_tag_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         low_pos_ff   <= low_pos_in;
         high_pos_ff  <= high_pos_in;
         open_ff      <= open_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         pop_act_ff   <= pop_act_in;
         rsp_valid_ff <= rsp_valid_in;
         live_ff      <= live_in;
         cnt_ff       <= cnt_in;
         open_tag_ff  <= open_tag_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_side_ff     <= op_side_in;
      op_tag_ff      <= op_tag_in;
      op_size_ff     <= op_size_in;
      op_amask_ff    <= op_amask_in;
      acc_ff         <= acc_in;
      res_status_ff  <= res_status_in;
      res_have_ff    <= res_have_in;
      res_addr_ff    <= res_addr_in;
      scan_idx_ff    <= scan_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      fidx_ff        <= fidx_in;
      pop_cnt_ff     <= pop_cnt_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // one mark list per side: {tag, position at mark begin}
   for (genvar g = 0; g < SIDES; g++) begin : g_side
      desa_ram #(
         .WIDTH (RW),
         .DEPTH (MARKS_PER_SIDE)
      ) u_mark_ram (
         .clock   (clock),
         .wr_en   (ram_we[g]),
         .wr_addr (ram_waddr),
         .wr_data (ram_wdata),
         .rd_addr (ram_raddr[g]),
         .rd_data (ram_rdata[g])
      );
      assign top_live_ok[g] = (cnt_ff[g] == '0) || live_ff[g][cnt_ff[g][IW-1:0] - IW'(1)];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

   // ---------------------------------------------------------------- assertions
   a_open_has_mark: assert property (@(posedge clock) disable iff (reset)
      !(open_ff[0] && (cnt_ff[0] == '0)) && !(open_ff[1] && (cnt_ff[1] == '0)))
      else $error("open mark on a side with an empty mark list");

   a_top_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (top_live_ok == 2'b11))
      else $error("newest mark of a side is not live while idle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request taken while the previous one is still in progress");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output step");

endmodule

// ===== dv/tb_double_ended_stack_allocator_unit.sv =====
// Self-checking testbench for double_ended_stack_allocator_unit: directed and random requests,
// predicted per request on acceptance and checked against every response.
// Depends on desa_pkg and the allocator RTL; needs nothing else to run.
`timescale 1ns / 1ps
module tb_double_ended_stack_allocator_unit;
   import desa_pkg::*;

   localparam int MARKS      = MARKS_PER_SIDE_DEF;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_REQS = 230;
   // longest free: scan of both mark lists plus pop walk, with margin
   localparam int QUIET_CYCLES = 100;

   // one request as presented on the req_ side
   typedef struct packed {
      mode_type               mode;
      logic                   side;
      logic [TAG_W-1:0]       tag;
      logic [SIZE_W-1:0]      size;
      logic [ALIGN_W-1:0]     align;
   } alloc_req_type;

   // one response as expected on the rsp_ side
   typedef struct packed {
      logic [ADDR_W-1:0]      address;
      status_type             status;
   } alloc_rsp_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [MODE_W-1:0]      req_mode;
   logic                   req_side;
   logic [TAG_W-1:0]       req_tag;
   logic [SIZE_W-1:0]      req_alloc_size;
   logic [ALIGN_W-1:0]     req_align_log2;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [ADDR_W-1:0]      rsp_address;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   csr_wr_en;
   logic [CSR_W-1:0]       csr_wr_data;

   double_ended_stack_allocator_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_side       (req_side),
      .req_tag        (req_tag),
      .req_alloc_size (req_alloc_size),
      .req_align_log2 (req_align_log2),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_address    (rsp_address),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // ------------------------------------------------------------------
   // Arena shadow: positions, mark lists and open marks of both sides
   // ------------------------------------------------------------------
   logic [31:0]        arena_size;
   logic [31:0]        low_pos;
   logic [31:0]        high_pos;
   logic [TAG_W-1:0]   mk_tag  [0:2*MARKS-1];
   logic [31:0]        mk_pos  [0:2*MARKS-1];
   bit                 mk_live [0:2*MARKS-1];
   int                 mk_count      [0:1];
   bit                 side_open     [0:1];
   logic [TAG_W-1:0]   side_open_tag [0:1];

   alloc_req_type      pending_q[$];     // requests still to be driven
   alloc_rsp_type      expected_q[$];    // responses owed by the block, oldest first
   alloc_req_type      held_req;         // request currently on the req_ port
   int                 mismatches;
   int                 send_idle_pct;
   int                 recv_stall_pct;

   // Stimulus-side view of the mark stacks, used only to shape well-formed sequences
   logic [TAG_W-1:0]   gen_tag   [0:1][0:MARKS-1];
   int                 gen_depth [0:1];
   bit                 gen_open  [0:1];

   // Load a new region size and drop everything, as a csr write or reset does
   function automatic void arena_reinit(logic [31:0] size_bytes);
      arena_size = size_bytes;
      low_pos    = '0;
      high_pos   = size_bytes;
      for (int i = 0; i < 2*MARKS; i++) begin
         mk_tag[i]  = '0;
         mk_pos[i]  = '0;
         mk_live[i] = 1'b0;
      end
      for (int s = 0; s < 2; s++) begin
         mk_count[s]      = 0;
         side_open[s]     = 1'b0;
         side_open_tag[s] = '0;
         gen_depth[s]     = 0;
         gen_open[s]      = 1'b0;
      end
   endfunction

   // Work out the response to one accepted request and advance the arena shadow
   function automatic alloc_rsp_type predict_response(alloc_req_type r);
      alloc_rsp_type res;
      logic [63:0] amask;
      logic [63:0] start;
      logic [63:0] fin;
      logic [31:0] roll_pos;
      int          found [0:1];
      bit          any;
      bit          have_addr;
      int          sd;
      int          e;
      int          cnt;
      sd        = r.side;
      amask     = (64'd1 << r.align) - 64'd1;
      have_addr = 1'b0;
      res.address = '0;
      res.status  = STAT_OK;
      case (r.mode)
         MODE_BEGIN: begin
            if (side_open[sd]) begin
               res.status = STAT_MARK_OPEN;
            end else if (mk_count[sd] >= MARKS) begin
               res.status = STAT_LIST_FULL;
            end else begin
               // push tag and current position, and leave the mark open
               e = sd*MARKS + mk_count[sd];
               mk_tag[e]  = r.tag;
               mk_pos[e]  = sd ? high_pos : low_pos;
               mk_live[e] = 1'b1;
               mk_count[sd]++;
               side_open[sd]     = 1'b1;
               side_open_tag[sd] = r.tag;
            end
         end
         MODE_END: begin
            if (!side_open[sd])
               res.status = STAT_NO_OPEN;
            else if (side_open_tag[sd] != r.tag)
               res.status = STAT_TAG_MISMATCH;
            else
               side_open[sd] = 1'b0;
         end
         MODE_ALLOC: begin
            // exact 64-bit sums: nothing wraps past the top of the region
            if (sd == 0) begin
               start = ({32'd0, low_pos} + amask) & ~amask;
               fin   = start + {32'd0, r.size};
               if (fin > {32'd0, high_pos}) begin
                  res.status = STAT_OOM;
               end else begin
                  low_pos     = fin[31:0];
                  res.address = start[31:0];
                  have_addr   = 1'b1;
               end
            end else if ({32'd0, r.size} > {32'd0, high_pos}) begin
               res.status = STAT_OOM;
            end else begin
               start = ({32'd0, high_pos} - {32'd0, r.size}) & ~amask;
               if (start < {32'd0, low_pos}) begin
                  res.status = STAT_OOM;
               end else begin
                  high_pos    = start[31:0];
                  res.address = start[31:0];
                  have_addr   = 1'b1;
               end
            end
         end
         default: begin
            // free by tag: lowest live match per side, low side checked first
            any = 1'b0;
            for (int s = 0; s < 2; s++) begin
               found[s] = -1;
               for (int i = 0; i < mk_count[s]; i++)
                  if (found[s] < 0 && mk_live[s*MARKS+i] && mk_tag[s*MARKS+i] == r.tag)
                     found[s] = i;
               if (found[s] >= 0) begin
                  any = 1'b1;
                  if (res.status == STAT_OK) begin
                     if (side_open[s])
                        res.status = STAT_MARK_OPEN;
                     else if (found[s] + 1 != mk_count[s])
                        res.status = STAT_NOT_NEWEST;
                  end
               end
            end
            if (!any)
               res.status = STAT_NOT_FOUND;
            if (res.status == STAT_OK) begin
               for (int s = 0; s < 2; s++) begin
                  if (found[s] >= 0) begin
                     // drop the mark, then pop any older ones already freed
                     e   = s*MARKS;
                     cnt = found[s];
                     roll_pos = mk_pos[e+cnt];
                     mk_live[e+cnt] = 1'b0;
                     while (cnt > 0 && !mk_live[e+cnt-1]) begin
                        roll_pos = mk_pos[e+cnt-1];
                        cnt--;
                     end
                     mk_count[s] = cnt;
                     if (s == 0)
                        low_pos = roll_pos;
                     else
                        high_pos = roll_pos;
                  end
               end
            end
         end
      endcase
      if (!have_addr)
         res.address = sd ? high_pos : low_pos;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic add_req(mode_type m, logic sd, logic [TAG_W-1:0] t,
                          logic [SIZE_W-1:0] sz, logic [ALIGN_W-1:0] al);
      alloc_req_type r;
      r.mode  = m;
      r.side  = sd;
      r.tag   = t;
      r.size  = sz;
      r.align = al;
      pending_q.push_back(r);
   endtask

   // Mostly small sizes, some scaled to the region, a few of any width
   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 5)
         return '0;
      if (k < 60)
         return $urandom_range(1, 64);
      if (k < 88)
         return $urandom_range(0, arena_size >> 4);
      return $urandom;
   endfunction

   function automatic logic [ALIGN_W-1:0] pick_align();
      if ($urandom_range(0, 99) < 70)
         return ALIGN_W'($urandom_range(0, 4));
      return ALIGN_W'($urandom_range(0, 31));
   endfunction

   // Queue one random request: mostly well-formed mark traffic, some noise
   task automatic queue_random_request();
      alloc_req_type r;
      int         pick;
      int         sd;
      int         other;
      sd      = $urandom_range(0, 1);
      other   = 1 - sd;
      r.side  = 1'(sd);
      r.tag   = TAG_W'($urandom);
      r.size  = pick_size();
      r.align = pick_align();
      pick    = $urandom_range(0, 99);
      if (pick < 8) begin
         // noise: any mode, any tag
         r.mode = MODE_W'($urandom);
      end else if (gen_open[sd]) begin
         if (pick < 60) begin
            r.mode = MODE_ALLOC;
         end else begin
            r.mode = MODE_END;
            if (pick < 95) begin
               r.tag = gen_tag[sd][gen_depth[sd]-1];
               gen_open[sd] = 1'b0;
            end
         end
      end else if (pick < 43) begin
         r.mode = MODE_BEGIN;
         // now and then reuse the tag on top of the other side
         if (pick < 15 && gen_depth[other] > 0)
            r.tag = gen_tag[other][gen_depth[other]-1];
         if (gen_depth[sd] < MARKS) begin
            gen_tag[sd][gen_depth[sd]] = r.tag;
            gen_depth[sd]++;
            gen_open[sd] = 1'b1;
         end
      end else if (pick < 70) begin
         r.mode = MODE_ALLOC;
      end else if (pick < 95) begin
         r.mode = MODE_FREE;
         if (gen_depth[sd] > 0) begin
            if (pick < 90) begin
               r.tag = gen_tag[sd][gen_depth[sd]-1];
               gen_depth[sd]--;
               if (gen_depth[other] > 0 && !gen_open[other] &&
                   gen_tag[other][gen_depth[other]-1] == r.tag)
                  gen_depth[other]--;
            end else begin
               // out of order: the oldest mark on the side
               r.tag = gen_tag[sd][0];
            end
         end
      end else begin
         // end with nothing open
         r.mode = MODE_END;
      end
      pending_q.push_back(r);
   endtask

   // Hold until every request has been answered, then let the block settle
   task automatic wait_for_drain();
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_total_size(logic [31:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      arena_reinit(value);
   endtask

   task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%t: %s mismatch, expected 0x%08h, got 0x%08h", $realtime, what, want, got);
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Request driver: present queued requests, hold each until accepted
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      alloc_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict on acceptance so the shadow follows the block's order
         if (req_valid && req_ready)
            expected_q.push_back(predict_response(held_req));
         if (!req_valid || req_ready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt      = pending_q.pop_front();
               held_req = nxt;
               req_valid      <= 1'b1;
               req_mode       <= nxt.mode;
               req_side       <= nxt.side;
               req_tag        <= nxt.tag;
               req_alloc_size <= nxt.size;
               req_align_log2 <= nxt.align;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------
   // Response monitor: compare each accepted response with the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      alloc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            flag_mismatch("unrequested response address", '0, rsp_address);
         end else begin
            want = expected_q.pop_front();
            if (rsp_address !== want.address)
               flag_mismatch("address", want.address, rsp_address);
            if (rsp_status !== want.status)
               flag_mismatch("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_BEGIN;
      req_side       = 1'b0;
      req_tag        = '0;
      req_alloc_size = '0;
      req_align_log2 = '0;
      rsp_ready      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      mismatches     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      arena_reinit(TOTAL_SIZE_RESET);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // cycle through idling patterns: none, sender, receiver, both
         case (phase % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         case (phase)
            0: begin
               // directed pass on the reset region size
               add_req(MODE_ALLOC, 1'b0, 16'h0000, 32'd0,          5'd0);
               add_req(MODE_ALLOC, 1'b0, 16'h0000, 32'd1,          5'd0);
               add_req(MODE_ALLOC, 1'b0, 16'h0000, 32'd0,          5'd4);  // zero size aligns
               add_req(MODE_ALLOC, 1'b0, 16'hFFFF, 32'hFFFF_FFFF,  5'd31); // out of memory
               add_req(MODE_ALLOC, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,  5'd0);  // larger than high
               add_req(MODE_ALLOC, 1'b1, 16'h0000, 32'h0000_0100,  5'd31); // aligns below low
               add_req(MODE_BEGIN, 1'b0, 16'hFFFF, 32'd0,          5'd0);
               add_req(MODE_BEGIN, 1'b0, 16'h0001, 32'd0,          5'd0);  // mark already open
               add_req(MODE_END,   1'b0, 16'h1234, 32'd0,          5'd0);  // wrong tag
               add_req(MODE_END,   1'b0, 16'hFFFF, 32'd0,          5'd0);
               add_req(MODE_END,   1'b0, 16'hFFFF, 32'd0,          5'd0);  // nothing open
               add_req(MODE_ALLOC, 1'b0, 16'h0000, 32'h0000_0040,  5'd3);  // inside a mark
               add_req(MODE_FREE,  1'b1, 16'h5555, 32'd0,          5'd0);  // unknown tag
               add_req(MODE_BEGIN, 1'b1, 16'h0000, 32'd0,          5'd0);
               add_req(MODE_ALLOC, 1'b1, 16'h0000, 32'h0000_0100,  5'd8);
               add_req(MODE_FREE,  1'b1, 16'h0000, 32'd0,          5'd0);  // free while open
               add_req(MODE_END,   1'b1, 16'h0000, 32'd0,          5'd0);
               add_req(MODE_BEGIN, 1'b0, 16'hAAAA, 32'd0,          5'd0);
               add_req(MODE_END,   1'b0, 16'hAAAA, 32'd0,          5'd0);
               add_req(MODE_FREE,  1'b0, 16'hFFFF, 32'd0,          5'd0);  // not the newest
               add_req(MODE_FREE,  1'b0, 16'hAAAA, 32'd0,          5'd0);
               add_req(MODE_FREE,  1'b0, 16'hFFFF, 32'd0,          5'd0);  // rolls low back
               add_req(MODE_BEGIN, 1'b0, 16'h0000, 32'd0,          5'd0);  // tag on both sides
               add_req(MODE_END,   1'b0, 16'h0000, 32'd0,          5'd0);
               add_req(MODE_FREE,  1'b1, 16'h0000, 32'd0,          5'd0);  // frees both
               add_req(MODE_ALLOC, 1'b0, 16'h0000, 32'h1FFF_FFF0,  5'd0);  // exact fill
               add_req(MODE_ALLOC, 1'b0, 16'h0000, 32'd1,          5'd0);  // one byte over
               add_req(MODE_ALLOC, 1'b1, 16'h0000, 32'd0,          5'd0);  // meets low side
               // let the directed part finish so its fills do not starve the random part
               wait_for_drain();
               arena_reinit(arena_size);
               write_total_size(TOTAL_SIZE_RESET);
            end
            1: write_total_size(32'hFFFF_FFFF);
            2: write_total_size(32'd1);
            3: write_total_size(32'h0000_1000);
            4: write_total_size(32'h0000_0100);
            5: write_total_size($urandom | 32'd1);
            6: write_total_size(32'h8000_0000);
            default: write_total_size(32'd64);
         endcase
         for (int n = 0; n < PHASE_REQS; n++)
            queue_random_request();
         // pause the sender until every response of the phase is back
         wait_for_drain();
      end

      if (expected_q.size() != 0) begin
         $display("%0d responses never arrived", expected_q.size());
         mismatches += expected_q.size();
      end
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
